// ===== design/bta_pkg.sv =====
// ----------------------------------------------------------------------------
// bta_pkg: shared definitions for the boundary tag allocator
// Sizes, tag layout and command codes used by the allocator core.
// ----------------------------------------------------------------------------
`default_nettype none

package bta_pkg;

    localparam int ARENA_BYTES = 4096;
    localparam int TAG_BYTES   = 16;
    localparam int MIN_BLOCK   = 2 * TAG_BYTES + 1;

    // header positions stay below the arena size
    localparam int ADDR_W = $clog2(ARENA_BYTES);
    localparam int SIZE_W = 13;
    localparam int POS_W  = 14;

    // one tag: used mark and payload size
    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
    } tag_t;

    localparam int TAG_W = $bits(tag_t);

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INFO  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [POS_W-1:0] TWO_TAGS = POS_W'(2 * TAG_BYTES);

endpackage

`default_nettype wire

// ===== design/boundary_tag_first_fit_allocator_core.sv =====
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator_core: first-fit arena allocator
// Allocate, free and usage report over a chain of tagged blocks.
// ----------------------------------------------------------------------------
// An item carries a command in s_tuser and an amount in s_tdata; each item
// gives one result item. Block headers live in a single-port tag RAM with a
// registered read, so the chain walk sets the rate. An allocate reads and
// checks each block in turn until one fits, marks it used and, when the block
// is split, writes the header of the free remainder. A failed allocate and
// info walk the whole chain. A free walks to the target block, checks it,
// reads the next neighbor when there is one and then writes the freed header,
// merged with a free previous block. A zero-byte allocate, a free below the
// first payload and unknown commands skip the walk. The next item is taken
// only back in S_IDLE, and a result held back by m_tready stalls the block
// until it leaves. After reset or an arena_size write the block rewrites the
// first header before it takes an item.
`default_nettype none

module boundary_tag_first_fit_allocator_core
    import bta_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [12:0] amount
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata    // [0] ok, [12:1] offset, [19:13] used_blocks,
                                        // [32:20] used_bytes, [45:33] largest_free
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_EVAL, S_SPLIT, S_FWALK, S_FEVAL,
        S_FCHK, S_FNEXT, S_FWR, S_DONE
    } state_t;

    state_t            state_reg;
    logic              fmt_reg;
    logic [SIZE_W-1:0] arena_reg;
    cmd_t              cmd_reg;
    logic [SIZE_W-1:0] amt_reg;
    logic [POS_W-1:0]  p_reg;
    logic [POS_W-1:0]  target_reg;
    logic [ADDR_W-1:0] prev_reg;
    logic              has_prev_reg;
    logic              prev_used_reg;
    logic [SIZE_W-1:0] prev_size_reg;
    logic [SIZE_W-1:0] sz_reg;
    logic [6:0]        blocks_reg;
    logic [SIZE_W-1:0] bytes_reg;
    logic [SIZE_W-1:0] best_reg;
    logic              ok_reg;
    logic [11:0]       off_reg;
    logic              m_tvalid_reg;
    logic [47:0]       m_tdata_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    tag_t              mem_wdata;
    tag_t              mem_rdata;

    logic              cfg_wr;
    logic [SIZE_W-1:0] cfg_val;
    logic [POS_W-1:0]  arena_pos;
    logic [POS_W-1:0]  next_pos;
    logic [POS_W-1:0]  split_pos;
    logic              fits;
    logic              split;
    logic [SIZE_W-1:0] merged;

    assign pready    = 1'b1;
    assign prdata    = {19'd0, arena_reg};
    assign cfg_wr    = psel && penable && pwrite && !paddr[2];
    assign arena_pos = {1'b0, arena_reg};

    // clamp the written arena size
    always_comb
    begin
        if (pwdata[12:0] > SIZE_W'(ARENA_BYTES))
            cfg_val = SIZE_W'(ARENA_BYTES);
        else if (pwdata[12:0] < SIZE_W'(MIN_BLOCK))
            cfg_val = SIZE_W'(MIN_BLOCK);
        else
            cfg_val = pwdata[12:0];
    end

    // chain arithmetic on the header just read
    assign next_pos  = p_reg + TWO_TAGS + {1'b0, mem_rdata.size};
    assign split_pos = p_reg + TWO_TAGS + {1'b0, amt_reg};
    assign fits      = !mem_rdata.used && (mem_rdata.size >= amt_reg);
    assign split     = (mem_rdata.size - amt_reg) >= SIZE_W'(MIN_BLOCK);
    assign merged    = prev_size_reg + sz_reg + SIZE_W'(2 * TAG_BYTES);

    // tag RAM port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = p_reg[ADDR_W-1:0];
        mem_wdata = '0;
        case (state_reg)
            S_IDLE:
            begin
                mem_we    = fmt_reg;
                mem_addr  = '0;
                mem_wdata = '{used: 1'b0, size: arena_reg - SIZE_W'(2 * TAG_BYTES)};
            end
            S_EVAL:
            begin
                mem_we    = (cmd_reg == CMD_ALLOC) && fits;
                mem_wdata = '{used: 1'b1, size: split ? amt_reg : mem_rdata.size};
            end
            S_SPLIT:
            begin
                mem_we    = 1'b1;
                mem_addr  = split_pos[ADDR_W-1:0];
                mem_wdata = '{used: 1'b0, size: sz_reg};
            end
            S_FCHK:
            begin
                mem_addr = next_pos[ADDR_W-1:0];
            end
            S_FWR:
            begin
                mem_we = 1'b1;
                if (has_prev_reg && !prev_used_reg)
                begin
                    mem_addr  = prev_reg;
                    mem_wdata = '{used: 1'b0, size: merged};
                end
                else
                begin
                    mem_wdata = '{used: 1'b0, size: sz_reg};
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    bta_ram #(
        .WIDTH (TAG_W),
        .DEPTH (ARENA_BYTES)
    ) u_tags (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign s_tready = (state_reg == S_IDLE) && !fmt_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fmt_reg      <= 1'b1;
            arena_reg    <= SIZE_W'(ARENA_BYTES);
            m_tvalid_reg <= 1'b0;
            cmd_reg      <= CMD_NONE;
            has_prev_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            if (state_reg == S_IDLE && fmt_reg)
                fmt_reg <= 1'b0;
            if (cfg_wr)
            begin
                arena_reg <= cfg_val;
                fmt_reg   <= 1'b1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        cmd_reg      <= cmd_t'(s_tuser);
                        amt_reg      <= s_tdata[12:0];
                        p_reg        <= '0;
                        target_reg   <= {1'b0, s_tdata[12:0]} - POS_W'(TAG_BYTES);
                        has_prev_reg <= 1'b0;
                        blocks_reg   <= '0;
                        bytes_reg    <= '0;
                        best_reg     <= '0;
                        ok_reg       <= 1'b0;
                        off_reg      <= '0;
                        case (cmd_t'(s_tuser))
                            CMD_ALLOC:
                                state_reg <= (s_tdata[12:0] == '0) ? S_DONE : S_RD;
                            CMD_FREE:
                                state_reg <= (s_tdata[12:0] < SIZE_W'(TAG_BYTES))
                                             ? S_DONE : S_FWALK;
                            CMD_INFO:
                                state_reg <= S_RD;
                            default:
                                state_reg <= S_DONE;
                        endcase
                    end
                end
                S_RD:
                begin
                    if (p_reg >= arena_pos)
                    begin
                        ok_reg    <= (cmd_reg == CMD_INFO);
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    p_reg     <= next_pos;
                    state_reg <= S_RD;
                    if (cmd_reg == CMD_INFO)
                    begin
                        if (mem_rdata.used)
                        begin
                            blocks_reg <= blocks_reg + 7'd1;
                            bytes_reg  <= bytes_reg + mem_rdata.size;
                        end
                        else if (mem_rdata.size > best_reg)
                            best_reg <= mem_rdata.size;
                    end
                    else if (fits)
                    begin
                        p_reg     <= p_reg;
                        ok_reg    <= 1'b1;
                        off_reg   <= 12'(p_reg + POS_W'(TAG_BYTES));
                        sz_reg    <= mem_rdata.size - amt_reg - SIZE_W'(2 * TAG_BYTES);
                        state_reg <= split ? S_SPLIT : S_DONE;
                    end
                end
                S_SPLIT:
                    state_reg <= S_DONE;
                S_FWALK:
                begin
                    if (p_reg < arena_pos && p_reg < target_reg)
                        state_reg <= S_FEVAL;
                    else if (p_reg != target_reg || p_reg >= arena_pos)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_FCHK;
                end
                S_FEVAL:
                begin
                    prev_reg      <= p_reg[ADDR_W-1:0];
                    has_prev_reg  <= 1'b1;
                    prev_used_reg <= mem_rdata.used;
                    prev_size_reg <= mem_rdata.size;
                    p_reg         <= next_pos;
                    state_reg     <= S_FWALK;
                end
                S_FCHK:
                begin
                    sz_reg <= mem_rdata.size;
                    if (!mem_rdata.used)
                        state_reg <= S_DONE;
                    else if (next_pos < arena_pos)
                        state_reg <= S_FNEXT;
                    else
                        state_reg <= S_FWR;
                end
                S_FNEXT:
                begin
                    if (!mem_rdata.used)
                        sz_reg <= sz_reg + mem_rdata.size + SIZE_W'(2 * TAG_BYTES);
                    state_reg <= S_FWR;
                end
                S_FWR:
                begin
                    ok_reg    <= 1'b1;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {2'b00, best_reg, bytes_reg, blocks_reg,
                                         off_reg, ok_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    a_fmt_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        fmt_reg |-> !s_tready)
        else $error("item accepted before first header was rewritten");

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("item accepted while a command is in progress");

    a_fail_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[45:1] == '0))
        else $error("failed result carries nonzero fields");

    a_grant_past_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0] && m_tdata[12:1] != '0) |->
        (m_tdata[12:1] >= 12'(TAG_BYTES)))
        else $error("granted offset inside first header");

endmodule

`default_nettype wire

// ===== design/bta_ram.sv =====
// ----------------------------------------------------------------------------
// bta_ram: generic single-port RAM
// One address for read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read at the same address
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== sim/boundary_tag_first_fit_allocator_core_test.sv =====
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator_core_test: allocator core testbench
// Drives allocate, free and info items over several arena sizes and checks
// every result item against a local model of the block chain.
// ----------------------------------------------------------------------------
`default_nettype none

module boundary_tag_first_fit_allocator_core_test;
    import bta_pkg::*;

    localparam int WATCHDOG = 200000;
    localparam int STORE_N  = ARENA_BYTES + MIN_BLOCK;

    typedef struct packed {
        logic [1:0]  command;
        logic [12:0] amount;
    } op_item_t;

    // packed from the top bit down, so ok lands in bit 0
    typedef struct packed {
        logic [12:0] largest_free;
        logic [12:0] used_bytes;
        logic [6:0]  used_blocks;
        logic [11:0] offset;
        logic        ok;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire logic [31:0] prdata;
    wire logic pready;
    logic s_tvalid = 1'b0;
    wire logic s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    wire logic m_tvalid;
    logic m_tready = 1'b0;
    wire logic [47:0] m_tdata;

    boundary_tag_first_fit_allocator_core DUT (.*);

    always #2 clk = ~clk;

    // model of the tag chain
    logic        mdl_used [STORE_N];
    int unsigned mdl_size [STORE_N];
    int unsigned mdl_arena;
    int unsigned live_offs[$];

    op_item_t pending_ops[$];
    answer_t  expected_answers[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    bit  hold_long = 1'b0;
    int  s_gap = 0, m_gap = 0, hold_cnt = 0;
    logic s_tready_seen = 1'b0;

    function automatic void put_tag(int unsigned pos, logic u, int unsigned sz);
        int unsigned foot;
        foot = pos + TAG_BYTES + sz;
        if (pos < STORE_N) begin
            mdl_used[pos] = u;
            mdl_size[pos] = sz;
        end
        if (foot < STORE_N) begin
            mdl_used[foot] = u;
            mdl_size[foot] = sz;
        end
    endfunction

    function automatic void format_arena(int unsigned v);
        v = v & 13'h1fff;
        if (v > ARENA_BYTES) v = ARENA_BYTES;
        if (v < MIN_BLOCK) v = MIN_BLOCK;
        mdl_arena = v;
        for (int i = 0; i < STORE_N; i++)
        begin
            mdl_used[i] = 1'b0;
            mdl_size[i] = 0;
        end
        put_tag(0, 1'b0, v - 2 * TAG_BYTES);
        live_offs.delete();
    endfunction

    function automatic answer_t predict_answer(op_item_t op);
        answer_t a;
        int unsigned p, prv, tgt, n, sz, blocks, bytes, best;
        bit has_prev;
        a = '0;
        p = 0;
        case (op.command)
            CMD_ALLOC:
            begin
                if (op.amount != 0) begin
                    while (p < mdl_arena) begin
                        sz = mdl_size[p];
                        if (!mdl_used[p] && sz >= op.amount) begin
                            if (sz - op.amount < MIN_BLOCK) put_tag(p, 1'b1, sz);
                            else begin
                                put_tag(p, 1'b1, op.amount);
                                put_tag(p + 2 * TAG_BYTES + op.amount, 1'b0,
                                        sz - op.amount - 2 * TAG_BYTES);
                            end
                            a.ok = 1'b1;
                            a.offset = 12'(p + TAG_BYTES);
                            live_offs.push_back(p + TAG_BYTES);
                            break;
                        end
                        p = p + 2 * TAG_BYTES + mdl_size[p];
                    end
                end
            end
            CMD_FREE:
            begin
                if (op.amount >= TAG_BYTES) begin
                    tgt = op.amount - TAG_BYTES;
                    prv = 0;
                    has_prev = 1'b0;
                    while (p < mdl_arena && p < tgt) begin
                        prv = p;
                        has_prev = 1'b1;
                        p = p + 2 * TAG_BYTES + mdl_size[p];
                    end
                    if (p == tgt && p < mdl_arena && mdl_used[p]) begin
                        sz = mdl_size[p];
                        put_tag(p, 1'b0, sz);
                        n = p + 2 * TAG_BYTES + sz;
                        if (n < mdl_arena && !mdl_used[n]) begin
                            sz = sz + mdl_size[n] + 2 * TAG_BYTES;
                            put_tag(p, 1'b0, sz);
                        end
                        if (has_prev && !mdl_used[prv]) begin
                            sz = mdl_size[prv] + sz + 2 * TAG_BYTES;
                            put_tag(prv, 1'b0, sz);
                        end
                        a.ok = 1'b1;
                    end
                end
            end
            CMD_INFO:
            begin
                blocks = 0;
                bytes = 0;
                best = 0;
                while (p < mdl_arena) begin
                    if (mdl_used[p]) begin
                        blocks++;
                        bytes += mdl_size[p];
                    end else if (mdl_size[p] > best) best = mdl_size[p];
                    p = p + 2 * TAG_BYTES + mdl_size[p];
                end
                a.ok = 1'b1;
                a.used_blocks = 7'(blocks);
                a.used_bytes = 13'(bytes);
                a.largest_free = 13'(best);
            end
            default: ;
        endcase
        return a;
    endfunction

    // queue one item and its expected answer
    task automatic send_op(logic [1:0] c, logic [12:0] amt);
        op_item_t op;
        op.command = c;
        op.amount = amt;
        pending_ops.push_back(op);
        expected_answers.push_back(predict_answer(op));
    endtask

    task automatic drain_all();
        while (pending_ops.size() != 0 || expected_answers.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] a, logic [31:0] d);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_arena(int unsigned v);
        apb_write(3'd0, v);
        format_arena(v);
    endtask

    // mostly well-formed alloc/free traffic, some noise
    task automatic random_phase(int count, int unsigned max_req);
        int r, k;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45) send_op(CMD_ALLOC, 13'($urandom_range(1, max_req)));
            else if (r < 80 && live_offs.size() != 0) begin
                k = $urandom_range(0, live_offs.size() - 1);
                send_op(CMD_FREE, 13'(live_offs[k]));
                live_offs.delete(k);
            end else if (r < 88) send_op(CMD_INFO, 13'($urandom));
            else if (r < 93) send_op(CMD_FREE, 13'($urandom));
            else if (r < 96) send_op(CMD_NONE, 13'($urandom));
            else send_op(CMD_ALLOC, 13'($urandom));
        end
    endtask

    // sender: drives at the falling edge
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready_seen) begin
                void'(pending_ops.pop_front());
            end
            if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!calm && !(s_tvalid && !s_tready_seen) && $urandom_range(0, 9) == 0) begin
                s_gap <= $urandom_range(1, 15);
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_ops[0].command;
                s_tdata <= {3'b000, pending_ops[0].amount};
            end else s_tvalid <= 1'b0;
        end
    end

    // input handshake seen at the rising edge
    always @(posedge clk)
        s_tready_seen <= s_tvalid && s_tready;

    // receiver readiness
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (hold_long) begin
                m_tready <= 1'b0;
                hold_cnt <= hold_cnt + 1;
                if (hold_cnt >= 400) begin
                    hold_long <= 1'b0;
                    hold_cnt <= 0;
                end
            end else if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                m_gap <= $urandom_range(1, 15);
                m_tready <= 1'b0;
            end else m_tready <= 1'b1;
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        answer_t got, exp_a;
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("FAILURE");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[45:0];
                if (expected_answers.size() == 0) begin
                    $error("result item with nothing expected: %h", m_tdata);
                    errors++;
                end else begin
                    exp_a = expected_answers.pop_front();
                    if (got.ok !== exp_a.ok) begin
                        $error("ok: expected %0d actual %0d", exp_a.ok, got.ok);
                        errors++;
                    end
                    if (got.offset !== exp_a.offset) begin
                        $error("offset: expected %0d actual %0d", exp_a.offset, got.offset);
                        errors++;
                    end
                    if (got.used_blocks !== exp_a.used_blocks) begin
                        $error("used_blocks: expected %0d actual %0d",
                               exp_a.used_blocks, got.used_blocks);
                        errors++;
                    end
                    if (got.used_bytes !== exp_a.used_bytes) begin
                        $error("used_bytes: expected %0d actual %0d",
                               exp_a.used_bytes, got.used_bytes);
                        errors++;
                    end
                    if (got.largest_free !== exp_a.largest_free) begin
                        $error("largest_free: expected %0d actual %0d",
                               exp_a.largest_free, got.largest_free);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        format_arena(4096);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes and special cases on the reset arena
        send_op(CMD_ALLOC, 13'd0);
        send_op(CMD_ALLOC, 13'd8191);
        send_op(CMD_ALLOC, 13'd4064);
        send_op(CMD_INFO, 13'd0);
        send_op(CMD_FREE, 13'd16);
        send_op(CMD_FREE, 13'd16);
        send_op(CMD_ALLOC, 13'd1);
        send_op(CMD_ALLOC, 13'd4031);
        send_op(CMD_ALLOC, 13'd100);
        send_op(CMD_ALLOC, 13'd200);
        send_op(CMD_FREE, 13'd0);
        send_op(CMD_FREE, 13'd15);
        send_op(CMD_FREE, 13'd20);
        send_op(CMD_FREE, 13'd8191);
        send_op(CMD_NONE, 13'h1fff);
        send_op(CMD_INFO, 13'h1fff);
        send_op(CMD_FREE, 13'd148);
        send_op(CMD_FREE, 13'd16);
        send_op(CMD_INFO, 13'd0);
        drain_all();

        // tiny arena, below minimum and above maximum
        set_arena(0);
        send_op(CMD_ALLOC, 13'd1);
        send_op(CMD_INFO, 13'd0);
        send_op(CMD_FREE, 13'd16);
        random_phase(60, 8);
        drain_all();
        set_arena(32'h1fff);
        random_phase(60, 300);
        drain_all();

        // back-pressure: receiver holds off while items keep coming
        set_arena(4096);
        hold_long = 1'b1;
        random_phase(300, 120);
        drain_all();

        set_arena(33);
        random_phase(80, 2);
        drain_all();
        set_arena(500);
        random_phase(300, 60);
        drain_all();
        set_arena(4096);
        random_phase(500, 200);
        drain_all();

        // last part: no idling
        calm = 1'b1;
        set_arena(2048);
        random_phase(400, 90);
        drain_all();

        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/bta_pkg.sv
design/bta_ram.sv
design/boundary_tag_first_fit_allocator_core.sv
sim/boundary_tag_first_fit_allocator_core_test.sv
